// ----- design/clipped_nibble_blit_writer_defines.svh -----
// Assertion macros for the checker of the blit writer.
`ifndef CLIPPED_NIBBLE_BLIT_WRITER_DEFINES_SVH
`define CLIPPED_NIBBLE_BLIT_WRITER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CNBW_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CNBW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/cnbw_pkg.sv -----
package cnbw_pkg;

    // Field widths of the register file and the clipped window.
    localparam int SIZE_W  = 11;
    localparam int POS_W   = 12;
    localparam int COORD_W = 11;
    localparam int BCOL_W  = 10;
    localparam int ADDR_W  = 15;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_DEST_X        = 2'd2,
        CFG_DEST_Y        = 2'd3
    } cfg_index_t;

    // Nibble enable codes.
    localparam logic [1:0] NE_LOW  = 2'b01;
    localparam logic [1:0] NE_HIGH = 2'b10;
    localparam logic [1:0] NE_BOTH = 2'b11;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       image_start;
    } in_word_t;

    typedef struct packed {
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        write_data;
        logic [1:0]        nibble_enable;
        logic              last;
    } out_word_t;

    typedef struct packed {
        logic [SIZE_W-1:0]        source_width;
        logic [SIZE_W-1:0]        source_height;
        logic signed [POS_W-1:0]  dest_x;
        logic signed [POS_W-1:0]  dest_y;
    } cfg_t;

    // Clipped window; the coordinates only matter when visible is set.
    typedef struct packed {
        logic               visible;
        logic [COORD_W-1:0] first_col;
        logic [COORD_W-1:0] vis_pixels;
        logic [COORD_W-1:0] first_row;
        logic [COORD_W-1:0] vis_rows;
        logic [COORD_W-1:0] scr_col;
        logic [COORD_W-1:0] scr_row;
    } clip_t;

endpackage

// ----- design/cnbw_clip.sv -----
module cnbw_clip #(
    parameter int SCREEN_WIDTH    = 220,
    parameter int SCREEN_HEIGHT   = 176,
    parameter int MAX_SOURCE_SIZE = 1024
) (
    input  cnbw_pkg::cfg_t                 cfg,
    output cnbw_pkg::clip_t                clip,
    output logic [cnbw_pkg::BCOL_W-1:0]    bytes_per_row
);
    import cnbw_pkg::*;

    // Signed working width: covers position plus size with margin.
    localparam int CW = 14;
    localparam logic [CW-1:0]        MAX_C = CW'(MAX_SOURCE_SIZE);
    localparam logic signed [CW-1:0] SW_C  = CW'(SCREEN_WIDTH);
    localparam logic signed [CW-1:0] SH_C  = CW'(SCREEN_HEIGHT);

    logic [CW-1:0]        w_sat;
    logic [CW-1:0]        h_sat;
    logic signed [CW-1:0] sx, sy, w, h, dx, dy;

    // Saturate the source size at the largest image and round width down to even.
    assign w_sat = (CW'(cfg.source_width) > MAX_C) ? MAX_C : CW'(cfg.source_width);
    assign h_sat = (CW'(cfg.source_height) > MAX_C) ? MAX_C : CW'(cfg.source_height);
    assign bytes_per_row = w_sat[BCOL_W:1];

    // Clip against the left, top, right and bottom screen edges in turn.
    always_comb begin
        sx = '0;
        sy = '0;
        w  = signed'({w_sat[CW-1:1], 1'b0});
        h  = signed'(h_sat);
        dx = CW'(cfg.dest_x);
        dy = CW'(cfg.dest_y);
        if (dx < 0) begin
            sx = -dx;
            w  = w + dx;
            dx = '0;
        end
        if (dy < 0) begin
            sy = -dy;
            h  = h + dy;
            dy = '0;
        end
        if (dx + w >= SW_C) begin
            w    = SW_C - dx;
            w[0] = 1'b0;
        end
        if (dy + h >= SH_C) begin
            h = SH_C - dy;
        end
        // An odd source start skips one pixel so whole bytes stay aligned.
        if (sx[0]) begin
            sx = sx + 1'b1;
            dx = dx + 1'b1;
            w  = w - 1'b1;
        end
    end

    // A window that is empty or negative in either direction draws nothing.
    always_comb begin
        clip.visible    = (w > 0) && (h > 0);
        clip.first_col  = sx[COORD_W-1:0];
        clip.vis_pixels = w[COORD_W-1:0];
        clip.first_row  = sy[COORD_W-1:0];
        clip.vis_rows   = h[COORD_W-1:0];
        clip.scr_col    = dx[COORD_W-1:0];
        clip.scr_row    = dy[COORD_W-1:0];
    end

endmodule

// ----- design/clipped_nibble_blit_writer.sv -----
// Clipped 4bpp blit writer. Source bytes (two pixels, left pixel in the high
// nibble) stream in row-major order, with image_start on the first byte of
// each image; the window is clipped against the screen from the register
// values seen with that byte. A byte goes through one input stage and one
// output register; a stalled output holds the byte in the input stage.
// Clipped bytes pass at one byte per cycle, and bytes at an even destination
// column, one whole-byte write each, keep that rate while the output is not
// stalled. At an odd destination column each visible byte makes two nibble
// writes, and the single output register sends at most one write per cycle,
// so such a byte holds the input stage until its second write is loaded.
// The user must write registers only while the block is idle; it does not enforce this.
module clipped_nibble_blit_writer #(
    parameter int SCREEN_WIDTH    = 220,
    parameter int SCREEN_HEIGHT   = 176,
    parameter int MAX_SOURCE_SIZE = 1024
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_write_enable,
    input  logic [cnbw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cnbw_pkg::POS_W-1:0]          cfg_write_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  cnbw_pkg::in_word_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output cnbw_pkg::out_word_t                 m_data
);
    import cnbw_pkg::*;

    localparam int HALF_W   = SCREEN_WIDTH / 2;
    localparam int PROD_W   = COORD_W + $clog2(HALF_W + 1);
    localparam int FULL_W   = PROD_W + 1;

    cfg_t                cfg_reg;
    clip_t               clip_live;
    clip_t               clip_reg;
    logic [BCOL_W-1:0]   bytes_per_row;

    logic [COORD_W-1:0]  row_reg, row_next, cur_row;
    logic [BCOL_W-1:0]   col_reg, col_next, cur_col;
    logic [BCOL_W:0]     col_inc;

    logic                a_valid_reg;
    logic [7:0]          a_byte_reg;
    logic [COORD_W-1:0]  a_row_reg;
    logic [BCOL_W-1:0]   a_col_reg;
    logic                a_live_reg;
    logic                phase_reg;

    logic                m_valid_reg;
    out_word_t           m_data_reg;

    logic                accept;
    logic                hit;
    logic                odd;
    logic                out_free;
    logic                a_done;
    logic                load_out;
    logic [COORD_W:0]    row_end;
    logic [BCOL_W-1:0]   col_first;
    logic [BCOL_W:0]     col_end;
    logic [COORD_W-1:0]  dest_row;
    logic [FULL_W-1:0]   addr_full;
    logic [ADDR_W-1:0]   base_addr;
    out_word_t           out_word;

    // Configuration register file.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_write_enable) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SOURCE_WIDTH:  cfg_reg.source_width  <= cfg_write_data[SIZE_W-1:0];
                CFG_SOURCE_HEIGHT: cfg_reg.source_height <= cfg_write_data[SIZE_W-1:0];
                CFG_DEST_X:        cfg_reg.dest_x        <= signed'(cfg_write_data);
                CFG_DEST_Y:        cfg_reg.dest_y        <= signed'(cfg_write_data);
                default: ;
            endcase
        end
    end

    cnbw_clip #(
        .SCREEN_WIDTH    (SCREEN_WIDTH),
        .SCREEN_HEIGHT   (SCREEN_HEIGHT),
        .MAX_SOURCE_SIZE (MAX_SOURCE_SIZE)
    ) u_clip (
        .cfg           (cfg_reg),
        .clip          (clip_live),
        .bytes_per_row (bytes_per_row)
    );

    assign accept = s_valid && s_ready;

    // Position of the incoming word and the counter advance past it.
    always_comb begin
        cur_row  = s_data.image_start ? '0 : row_reg;
        cur_col  = s_data.image_start ? '0 : col_reg;
        col_inc  = {1'b0, cur_col} + 1'b1;
        row_next = cur_row;
        col_next = cur_col;
        if (bytes_per_row != '0) begin
            if (col_inc >= {1'b0, bytes_per_row}) begin
                col_next = '0;
                if (cur_row != '1) begin
                    row_next = cur_row + 1'b1;
                end
            end else begin
                col_next = col_inc[BCOL_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg  <= '0;
            col_reg  <= '0;
            clip_reg <= '0;
        end else if (accept) begin
            row_reg <= row_next;
            col_reg <= col_next;
            if (s_data.image_start) begin
                clip_reg <= clip_live;
            end
        end
    end

    // Input stage: holds one word and where it sits in the source image.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (accept) begin
            a_valid_reg <= 1'b1;
        end else if (a_done) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            a_byte_reg <= s_data.source_byte;
            a_row_reg  <= cur_row;
            a_col_reg  <= cur_col;
            a_live_reg <= (bytes_per_row != '0);
        end
    end

    // Window test against the clipped rows and byte columns.
    assign row_end   = {1'b0, clip_reg.first_row} + {1'b0, clip_reg.vis_rows};
    assign col_first = clip_reg.first_col[COORD_W-1:1];
    assign col_end   = {1'b0, col_first} + {1'b0, clip_reg.vis_pixels[COORD_W-1:1]};
    assign hit = a_live_reg && clip_reg.visible
              && (a_row_reg >= clip_reg.first_row)
              && ({1'b0, a_row_reg} < row_end)
              && (a_col_reg >= col_first)
              && ({1'b0, a_col_reg} < col_end);
    assign odd = clip_reg.scr_col[0];

    // Frame buffer byte address of the base byte.
    assign dest_row  = clip_reg.scr_row + (a_row_reg - clip_reg.first_row);
    assign addr_full = FULL_W'(FULL_W'(dest_row) * FULL_W'(HALF_W))
                     + FULL_W'(clip_reg.scr_col[COORD_W-1:1])
                     + FULL_W'(a_col_reg - col_first);
    assign base_addr = addr_full[ADDR_W-1:0];

    // An odd column writes the high nibble of the next byte, then the low nibble.
    always_comb begin
        if (odd && !phase_reg) begin
            out_word.write_address = base_addr + 1'b1;
            out_word.write_data    = {a_byte_reg[3:0], 4'h0};
            out_word.nibble_enable = NE_HIGH;
            out_word.last          = 1'b0;
        end else if (odd) begin
            out_word.write_address = base_addr;
            out_word.write_data    = {4'h0, a_byte_reg[7:4]};
            out_word.nibble_enable = NE_LOW;
            out_word.last          = 1'b1;
        end else begin
            out_word.write_address = base_addr;
            out_word.write_data    = a_byte_reg;
            out_word.nibble_enable = NE_BOTH;
            out_word.last          = 1'b1;
        end
    end

    // Stage handoff: a word leaves once all its writes are in the output register.
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = a_valid_reg && hit && out_free;
    assign a_done   = a_valid_reg && (!hit || (out_free && (!odd || phase_reg)));
    assign s_ready  = !a_valid_reg || a_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= 1'b0;
        end else if (load_out && odd && !phase_reg) begin
            phase_reg <= 1'b1;
        end else if (a_done) begin
            phase_reg <= 1'b0;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= out_word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- design/cnbw_checker.sv -----
`include "clipped_nibble_blit_writer_defines.svh"

module cnbw_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_valid,
    input logic                 m_ready,
    input cnbw_pkg::out_word_t  m_data
);
    import cnbw_pkg::*;

    // A stalled write holds its contents.
    `CNBW_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "write changed while stalled")

    // Only the high-nibble write of a split pair is not the last of its word.
    `CNBW_ASSERT_NOW(a_last, aclk, aresetn, m_valid, m_data.last == (m_data.nibble_enable != NE_HIGH), "last flag disagrees with nibble enable")

    // The low-nibble half follows at once, one byte below.
    `CNBW_ASSERT_NEXT(a_pair, aclk, aresetn, m_valid && m_ready && m_data.nibble_enable == NE_HIGH, m_valid && m_data.nibble_enable == NE_LOW && m_data.write_address == $past(m_data.write_address) - 1'b1, "split write pair broken")

    // Low-nibble writes carry the pixel in the enabled half only.
    `CNBW_ASSERT_NOW(a_low_data, aclk, aresetn, m_valid && m_data.nibble_enable == NE_LOW, m_data.write_data[7:4] == 4'h0, "low-nibble write with stray high bits")

endmodule

bind clipped_nibble_blit_writer cnbw_checker u_checker (.*);

// ----- verif/tb_clipped_nibble_blit_writer.sv -----
`timescale 1ns / 1ps

module tb_clipped_nibble_blit_writer;
    import cnbw_pkg::*;

    localparam int SCREEN_W      = 220;
    localparam int SCREEN_H      = 176;
    localparam int MAX_SIZE      = 1024;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_WORDS  = 850;

    logic              aclk             = 1'b0;
    logic              aresetn          = 1'b0;
    logic              cfg_write_enable = 1'b0;
    cfg_index_t        cfg_index        = CFG_SOURCE_WIDTH;
    logic [POS_W-1:0]  cfg_write_data   = '0;
    logic              s_valid          = 1'b0;
    logic              s_ready;
    in_word_t          s_data           = '0;
    logic              m_valid;
    logic              m_ready          = 1'b0;
    out_word_t         m_data;

    // Register shadow as the block should see it.
    logic [SIZE_W-1:0]       reg_width  = '0;
    logic [SIZE_W-1:0]       reg_height = '0;
    logic signed [POS_W-1:0] reg_dx     = '0;
    logic signed [POS_W-1:0] reg_dy     = '0;

    // Position of the current source byte and the clipped window.
    int src_row, src_bcol;
    int win_first_col, win_pixels, win_first_row, win_rows, win_scr_col, win_scr_row;

    out_word_t pending_writes[$];
    int        fail_count   = 0;
    int        cycle_count  = 0;
    int        words_sent   = 0;
    int        tx_idle_pct  = 0;
    int        rx_stall_pct = 0;

    clipped_nibble_blit_writer #(
        .SCREEN_WIDTH    (SCREEN_W),
        .SCREEN_HEIGHT   (SCREEN_H),
        .MAX_SOURCE_SIZE (MAX_SIZE)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_write_data   (cfg_write_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data)
    );

    initial forever #5 aclk = ~aclk;

    // Clip the image against the screen using the registers as they are now.
    function automatic void clip_window();
        int sx, sy, w, h, dx, dy;
        sx = 0;
        sy = 0;
        w  = (reg_width > MAX_SIZE) ? MAX_SIZE : int'(reg_width);
        w  = w - (w % 2);
        h  = (reg_height > MAX_SIZE) ? MAX_SIZE : int'(reg_height);
        dx = reg_dx;
        dy = reg_dy;
        if (dx < 0) begin
            sx = -dx;
            w  = w + dx;
            dx = 0;
        end
        if (dy < 0) begin
            sy = -dy;
            h  = h + dy;
            dy = 0;
        end
        if (dx + w >= SCREEN_W) begin
            w = SCREEN_W - dx;
            if ((w & 1) != 0) w--;
        end
        if (dy + h >= SCREEN_H) h = SCREEN_H - dy;
        // An odd source start moves both the source and the screen column by one.
        if ((sx & 1) != 0) begin
            sx++;
            dx++;
            w--;
        end
        win_first_col = sx;
        win_pixels    = w;
        win_first_row = sy;
        win_rows      = h;
        win_scr_col   = dx;
        win_scr_row   = dy;
    endfunction

    // Work out the frame-buffer writes that one source word causes.
    function automatic void predict_frame_writes(in_word_t word);
        int        eff_w, bpr, c0, nb, base;
        out_word_t wr;
        eff_w = (reg_width > MAX_SIZE) ? MAX_SIZE : int'(reg_width);
        bpr   = eff_w / 2;
        if (word.image_start) begin
            clip_window();
            src_row  = 0;
            src_bcol = 0;
        end
        if (bpr != 0 && win_pixels > 0 && win_rows > 0) begin
            c0 = win_first_col / 2;
            nb = win_pixels / 2;
            if (src_row >= win_first_row && src_row < win_first_row + win_rows &&
                src_bcol >= c0 && src_bcol < c0 + nb) begin
                base = (win_scr_row + src_row - win_first_row) * (SCREEN_W / 2) +
                       win_scr_col / 2 + src_bcol - c0;
                if ((win_scr_col & 1) != 0) begin
                    // Odd screen column: the byte straddles two frame-buffer bytes.
                    wr.write_address = ADDR_W'(base + 1);
                    wr.write_data    = {word.source_byte[3:0], 4'h0};
                    wr.nibble_enable = NE_HIGH;
                    wr.last          = 1'b0;
                    pending_writes.push_back(wr);
                    wr.write_address = ADDR_W'(base);
                    wr.write_data    = {4'h0, word.source_byte[7:4]};
                    wr.nibble_enable = NE_LOW;
                    wr.last          = 1'b1;
                    pending_writes.push_back(wr);
                end else begin
                    wr.write_address = ADDR_W'(base);
                    wr.write_data    = word.source_byte;
                    wr.nibble_enable = NE_BOTH;
                    wr.last          = 1'b1;
                    pending_writes.push_back(wr);
                end
            end
        end
        // The byte counter follows the live width register.
        if (bpr != 0) begin
            src_bcol++;
            if (src_bcol >= bpr) begin
                src_bcol = 0;
                if (src_row < 2047) src_row++;
            end
        end
    endfunction

    // Predict on every accepted source word.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) predict_frame_writes(s_data);
    end

    // Compare every accepted write with the oldest prediction.
    always @(posedge aclk) begin
        out_word_t exp_wr;
        if (aresetn && m_valid && m_ready) begin
            if (pending_writes.size() == 0) begin
                $error("unexpected write: address %0d data %0h", m_data.write_address,
                       m_data.write_data);
                fail_count++;
            end else begin
                exp_wr = pending_writes.pop_front();
                if (m_data.write_address !== exp_wr.write_address) begin
                    $error("write_address expected %0d got %0d", exp_wr.write_address,
                           m_data.write_address);
                    fail_count++;
                end
                if (m_data.write_data !== exp_wr.write_data) begin
                    $error("write_data expected %0h got %0h", exp_wr.write_data,
                           m_data.write_data);
                    fail_count++;
                end
                if (m_data.nibble_enable !== exp_wr.nibble_enable) begin
                    $error("nibble_enable expected %0d got %0d", exp_wr.nibble_enable,
                           m_data.nibble_enable);
                    fail_count++;
                end
                if (m_data.last !== exp_wr.last) begin
                    $error("last expected %0d got %0d", exp_wr.last, m_data.last);
                    fail_count++;
                end
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge aclk) m_ready <= ($urandom_range(99) >= rx_stall_pct);

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Send one source word and return at the edge that accepts it.
    task automatic send_word(input logic [7:0] pixels, input logic start);
        logic taken;
        if (tx_idle_pct != 0) begin
            while ($urandom_range(99) < tx_idle_pct) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid            <= 1'b1;
        s_data.source_byte <= pixels;
        s_data.image_start <= start;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        words_sent++;
    endtask

    // Stop sending and wait until every predicted write has come out.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_writes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [POS_W-1:0] value);
        cfg_write_enable <= 1'b1;
        cfg_index        <= idx;
        cfg_write_data   <= value;
        @(posedge aclk);
        cfg_write_enable <= 1'b0;
        case (idx)
            CFG_SOURCE_WIDTH:  reg_width  = value[SIZE_W-1:0];
            CFG_SOURCE_HEIGHT: reg_height = value[SIZE_W-1:0];
            CFG_DEST_X:        reg_dx     = value;
            CFG_DEST_Y:        reg_dy     = value;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic configure(input int w, input int h, input int dx, input int dy);
        write_reg(CFG_SOURCE_WIDTH, POS_W'(w));
        write_reg(CFG_SOURCE_HEIGHT, POS_W'(h));
        write_reg(CFG_DEST_X, POS_W'(dx));
        write_reg(CFG_DEST_Y, POS_W'(dy));
    endtask

    // After reset the window is empty, so words without an image start draw nothing.
    task automatic test_before_image();
        send_word(8'hFF, 1'b0);
        send_word(8'h00, 1'b0);
        settle();
    endtask

    // Even screen column: whole-byte writes, then a word past the image end.
    task automatic test_even_column();
        configure(4, 2, 10, 5);
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'hA5, 1'b0);
        send_word(8'h5A, 1'b0);
        send_word(8'h3C, 1'b0);
        settle();
    endtask

    // Odd screen column at the bottom right corner of the screen.
    task automatic test_odd_column();
        configure(4, 2, 217, 174);
        send_word(8'hFF, 1'b1);
        send_word(8'h0F, 1'b0);
        send_word(8'hF0, 1'b0);
        send_word(8'h81, 1'b0);
        settle();
    endtask

    // Negative position on the left and top, with an odd source start column.
    task automatic test_edge_clipping();
        configure(4, 2, -1, -1);
        send_word(8'h12, 1'b1);
        send_word(8'h34, 1'b0);
        send_word(8'h56, 1'b0);
        send_word(8'h78, 1'b0);
        settle();
    endtask

    // Odd width rounds down; zero width draws nothing.
    task automatic test_odd_and_zero_width();
        configure(3, 2, 4, 4);
        send_word(8'hC3, 1'b1);
        send_word(8'h96, 1'b0);
        settle();
        configure(0, 3, 0, 0);
        send_word(8'hE7, 1'b1);
        settle();
    endtask

    // Oversize registers and the extreme positions.
    task automatic test_oversize_and_extremes();
        configure(2047, 2047, -2048, -2048);
        send_word(8'h11, 1'b1);
        settle();
        configure(1100, 1, 0, 0);
        send_word(8'h22, 1'b1);
        send_word(8'h33, 1'b0);
        settle();
        configure(2, 1, 2047, 2047);
        send_word(8'h44, 1'b1);
        settle();
        configure(1024, 1024, -1, 175);
        send_word(8'h55, 1'b1);
        send_word(8'h66, 1'b0);
        settle();
    endtask

    // The bytes per row follow a width written in the middle of an image.
    task automatic test_width_change();
        configure(4, 4, 0, 0);
        send_word(8'h9A, 1'b1);
        send_word(8'hBC, 1'b0);
        settle();
        write_reg(CFG_SOURCE_WIDTH, POS_W'(2));
        send_word(8'hDE, 1'b0);
        send_word(8'hF1, 1'b0);
        settle();
    endtask

    // Random images: mostly well-formed, some without a start or with a stray one.
    task automatic run_random_image();
        int w, h, dx, dy, bpr, heff, count, i;
        if ($urandom_range(99) < 85) begin
            case ($urandom_range(9))
                0:       w = $urandom_range(2047);
                1:       w = $urandom_range(1);
                default: w = $urandom_range(24);
            endcase
            case ($urandom_range(9))
                0:       h = $urandom_range(2047);
                1:       h = 0;
                default: h = $urandom_range(1, 10);
            endcase
            dx = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(260) - 30;
            dy = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(210) - 20;
            settle();
            // Bit 11 of the size writes is not stored; toggle it anyway.
            write_reg(CFG_SOURCE_WIDTH, {1'($urandom_range(1)), SIZE_W'(w)});
            write_reg(CFG_SOURCE_HEIGHT, {1'($urandom_range(1)), SIZE_W'(h)});
            write_reg(CFG_DEST_X, POS_W'(dx));
            write_reg(CFG_DEST_Y, POS_W'(dy));
        end
        bpr   = ((reg_width > MAX_SIZE) ? MAX_SIZE : int'(reg_width)) / 2;
        heff  = (reg_height > MAX_SIZE) ? MAX_SIZE : int'(reg_height);
        count = bpr * heff;
        if (count > 80) count = 80;
        if ($urandom_range(3) == 0) count += $urandom_range(3);
        if (count == 0) count = $urandom_range(1, 3);
        for (i = 0; i < count; i++) begin
            if (i == 0) send_word(8'($urandom), $urandom_range(99) < 90);
            else send_word(8'($urandom), $urandom_range(99) < 2);
        end
    endtask

    task automatic test_random_images();
        int phase, goal;
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 72; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 72; end
                default: begin tx_idle_pct = 23; rx_stall_pct = 23; end
            endcase
            goal = words_sent + RANDOM_WORDS / 4;
            while (words_sent < goal) run_random_image();
        end
        settle();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_before_image();
        test_even_column();
        test_odd_column();
        test_edge_clipping();
        test_odd_and_zero_width();
        test_oversize_and_extremes();
        test_width_change();
        test_random_images();
        if (pending_writes.size() != 0) begin
            $error("%0d predicted writes never came out", pending_writes.size());
            fail_count++;
        end
        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule
